### sv/lmc_pkg.sv
package lmc_pkg;

    localparam int KEYS  = 1024;
    localparam int TRACE = 4096;
    localparam int SIZES = 1024;

    localparam int KW = $clog2(KEYS);
    localparam int PW = $clog2(TRACE + 1);
    localparam int TW = $clog2(TRACE);
    localparam int HW = $clog2(SIZES + 1);
    localparam int MW = 13;
    localparam int DW = 11;

    localparam int CLEAR_LEN = (TRACE > KEYS) ?
        ((TRACE > SIZES + 1) ? TRACE : SIZES + 1) :
        ((KEYS > SIZES + 1) ? KEYS : SIZES + 1);
    localparam int CW = $clog2(CLEAR_LEN);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREV,
        ST_PFX_A,
        ST_PFX_B,
        ST_ADD_DEC,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_ADD_INC,
        ST_SCAN
    } state_t;

    function automatic logic [TW-1:0] tree_addr(input logic [PW-1:0] pos);
        tree_addr = pos[TW-1:0];
    endfunction

endpackage

### sv/lmc_ram.sv
module lmc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lru_miss_curve_core.sv
// LRU stack distance histogram. After reset the block clears its memories, one entry
// of each per cycle, with busy high. An access reads the key's last position, then
// walks the sum tree through the single read and write port: one
// update walk for a first access, two prefix walks and two update walks for a repeat,
// each at most 13 steps at 4096 positions. A miss count read sums the histogram from
// cache_size up to 1024, one histogram entry per cycle; a read above 1024 and an
// access past the end of the trace answer in the next cycle. Each result shows for
// one cycle with done high and cannot be held off; a new command is taken whenever
// busy is low, also in the cycle where done is high.
module lru_miss_curve_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [9:0]               key,
    input  logic [10:0]              cache_size,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [10:0]              cfg_data,
    output logic                     done,
    output logic [10:0]              distance,
    output logic                     cold,
    output logic [12:0]              misses,
    output logic                     overflow
);

    localparam int PW = lmc_pkg::PW;
    localparam int TW = lmc_pkg::TW;
    localparam int KW = lmc_pkg::KW;
    localparam int HW = lmc_pkg::HW;
    localparam int MW = lmc_pkg::MW;
    localparam int DW = lmc_pkg::DW;
    localparam int CW = lmc_pkg::CW;

    lmc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [KW-1:0] key_reg, key_next;
    logic [DW-1:0] lim_reg, lim_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] sum_reg, sum_next;
    logic [HW-1:0] d_reg, d_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [DW-1:0] wdist_reg, wdist_next;
    logic          wcold_reg, wcold_next;
    logic [DW-1:0] cfg_reg;
    logic          done_reg, done_next;
    logic [DW-1:0] distance_reg, distance_next;
    logic          cold_reg, cold_next;
    logic [MW-1:0] misses_reg, misses_next;
    logic          overflow_reg, overflow_next;

    logic          t_we, l_we, h_we;
    logic [TW-1:0] t_waddr, t_raddr;
    logic [PW-1:0] t_wdata, t_rdata;
    logic [KW-1:0] l_waddr, l_raddr;
    logic [PW-1:0] l_wdata, l_rdata;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [MW-1:0] h_wdata, h_rdata;

    logic [PW-1:0] p_low, p_down, sum_a, sum_b;
    logic [PW:0]   p_up;
    logic [DW-1:0] lim_eff;

    lmc_ram #(.DEPTH(1 << TW), .WIDTH(PW)) u_tree (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    lmc_ram #(.DEPTH(lmc_pkg::KEYS), .WIDTH(PW)) u_last (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    lmc_ram #(.DEPTH(lmc_pkg::SIZES + 1), .WIDTH(MW)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    assign p_low  = p_reg & (~p_reg + 1'b1);
    assign p_down = p_reg & (p_reg - 1'b1);
    assign p_up   = {1'b0, p_reg} + {1'b0, p_low};
    assign sum_a  = sum_reg + t_rdata;
    assign sum_b  = sum_reg - t_rdata;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            lim_eff = DW'(1);
        end
        else if (32'(cfg_reg) > lmc_pkg::SIZES)
        begin
            lim_eff = DW'(lmc_pkg::SIZES);
        end
        else
        begin
            lim_eff = cfg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            done_reg  <= 1'b0;
            cfg_reg   <= DW'(1024);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lim_reg      <= lim_next;
        prev_reg     <= prev_next;
        p_reg        <= p_next;
        sum_reg      <= sum_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        wdist_reg    <= wdist_next;
        wcold_reg    <= wcold_next;
        distance_reg <= distance_next;
        cold_reg     <= cold_next;
        misses_reg   <= misses_next;
        overflow_reg <= overflow_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pc_next       = pc_reg;
        key_next      = key_reg;
        lim_next      = lim_reg;
        prev_next     = prev_reg;
        p_next        = p_reg;
        sum_next      = sum_reg;
        d_next        = d_reg;
        acc_next      = acc_reg;
        wdist_next    = wdist_reg;
        wcold_next    = wcold_reg;
        done_next     = 1'b0;
        distance_next = distance_reg;
        cold_next     = cold_reg;
        misses_next   = misses_reg;
        overflow_next = overflow_reg;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;

        case (state_reg)
            lmc_pkg::ST_CLEAR:
            begin
                t_we    = 32'(clr_reg) < (1 << TW);
                t_waddr = TW'(clr_reg);
                l_we    = 32'(clr_reg) < lmc_pkg::KEYS;
                l_waddr = KW'(clr_reg);
                h_we    = 32'(clr_reg) <= lmc_pkg::SIZES;
                h_waddr = HW'(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == lmc_pkg::CLEAR_LEN - 1)
                begin
                    state_next = lmc_pkg::ST_IDLE;
                end
            end
            lmc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd)
                    begin
                        if (32'(cache_size) > lmc_pkg::SIZES)
                        begin
                            done_next     = 1'b1;
                            distance_next = '0;
                            cold_next     = 1'b0;
                            misses_next   = '0;
                            overflow_next = 1'b0;
                        end
                        else
                        begin
                            h_raddr    = HW'(cache_size);
                            d_next     = HW'(cache_size);
                            acc_next   = '0;
                            state_next = lmc_pkg::ST_SCAN;
                        end
                    end
                    else if (32'(pc_reg) == lmc_pkg::TRACE)
                    begin
                        done_next     = 1'b1;
                        distance_next = '0;
                        cold_next     = 1'b0;
                        misses_next   = '0;
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        l_raddr    = key[KW-1:0];
                        key_next   = key[KW-1:0];
                        lim_next   = lim_eff;
                        state_next = lmc_pkg::ST_PREV;
                    end
                end
            end
            lmc_pkg::ST_PREV:
            begin
                prev_next = l_rdata;
                if (l_rdata == '0)
                begin
                    wcold_next = 1'b1;
                    wdist_next = lim_reg;
                    state_next = lmc_pkg::ST_HIST_RD;
                end
                else
                begin
                    wcold_next = 1'b0;
                    p_next     = pc_reg;
                    sum_next   = '0;
                    t_raddr    = lmc_pkg::tree_addr(pc_reg);
                    state_next = lmc_pkg::ST_PFX_A;
                end
            end
            lmc_pkg::ST_PFX_A:
            begin
                sum_next = sum_a;
                if (p_down == '0)
                begin
                    p_next     = prev_reg;
                    t_raddr    = lmc_pkg::tree_addr(prev_reg);
                    state_next = lmc_pkg::ST_PFX_B;
                end
                else
                begin
                    p_next  = p_down;
                    t_raddr = lmc_pkg::tree_addr(p_down);
                end
            end
            lmc_pkg::ST_PFX_B:
            begin
                sum_next = sum_b;
                if (p_down == '0)
                begin
                    if (sum_b > PW'(lim_reg))
                    begin
                        wdist_next = lim_reg;
                    end
                    else
                    begin
                        wdist_next = DW'(sum_b);
                    end
                    p_next     = prev_reg;
                    t_raddr    = lmc_pkg::tree_addr(prev_reg);
                    state_next = lmc_pkg::ST_ADD_DEC;
                end
                else
                begin
                    p_next  = p_down;
                    t_raddr = lmc_pkg::tree_addr(p_down);
                end
            end
            lmc_pkg::ST_ADD_DEC:
            begin
                t_we    = 1'b1;
                t_waddr = lmc_pkg::tree_addr(p_reg);
                t_wdata = t_rdata - 1'b1;
                if (32'(p_up) > lmc_pkg::TRACE)
                begin
                    state_next = lmc_pkg::ST_HIST_RD;
                end
                else
                begin
                    p_next  = PW'(p_up);
                    t_raddr = lmc_pkg::tree_addr(PW'(p_up));
                end
            end
            lmc_pkg::ST_HIST_RD:
            begin
                h_raddr    = HW'(wdist_reg);
                state_next = lmc_pkg::ST_HIST_WR;
            end
            lmc_pkg::ST_HIST_WR:
            begin
                h_we       = 1'b1;
                h_waddr    = HW'(wdist_reg);
                h_wdata    = h_rdata + 1'b1;
                l_we       = 1'b1;
                l_waddr    = key_reg;
                l_wdata    = pc_reg + 1'b1;
                p_next     = pc_reg + 1'b1;
                t_raddr    = lmc_pkg::tree_addr(pc_reg + 1'b1);
                state_next = lmc_pkg::ST_ADD_INC;
            end
            lmc_pkg::ST_ADD_INC:
            begin
                t_we    = 1'b1;
                t_waddr = lmc_pkg::tree_addr(p_reg);
                t_wdata = t_rdata + 1'b1;
                if (32'(p_up) > lmc_pkg::TRACE)
                begin
                    pc_next       = pc_reg + 1'b1;
                    done_next     = 1'b1;
                    distance_next = wdist_reg;
                    cold_next     = wcold_reg;
                    misses_next   = '0;
                    overflow_next = 1'b0;
                    state_next    = lmc_pkg::ST_IDLE;
                end
                else
                begin
                    p_next  = PW'(p_up);
                    t_raddr = lmc_pkg::tree_addr(PW'(p_up));
                end
            end
            lmc_pkg::ST_SCAN:
            begin
                acc_next = acc_reg + h_rdata;
                if (32'(d_reg) == lmc_pkg::SIZES)
                begin
                    done_next     = 1'b1;
                    distance_next = '0;
                    cold_next     = 1'b0;
                    misses_next   = acc_reg + h_rdata;
                    overflow_next = 1'b0;
                    state_next    = lmc_pkg::ST_IDLE;
                end
                else
                begin
                    d_next  = d_reg + 1'b1;
                    h_raddr = d_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lmc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = state_reg != lmc_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign distance  = distance_reg;
    assign cold      = cold_reg;
    assign misses    = misses_reg;
    assign overflow  = overflow_reg;

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmc_pkg::ST_IDLE && start && !cmd && 32'(pc_reg) == lmc_pkg::TRACE)
        |=> (done_reg && overflow_reg))
        else $error("exhausted trace did not report overflow");

    a_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmc_pkg::ST_ADD_INC && state_next == lmc_pkg::ST_IDLE)
        |=> (pc_reg == $past(pc_reg) + 1'b1))
        else $error("position count did not advance after access");

    a_pfx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmc_pkg::ST_PFX_B)
        |=> (state_reg == lmc_pkg::ST_PFX_B || state_reg == lmc_pkg::ST_ADD_DEC))
        else $error("prefix walk left to wrong state");

    a_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmc_pkg::ST_IDLE && start && !cmd && 32'(pc_reg) != lmc_pkg::TRACE)
        |=> (state_reg == lmc_pkg::ST_PREV && !done_reg))
        else $error("access did not start lookup");

endmodule
